/* src/mbcs_pkg.sv */
// ---------------------------------------------------------------------------
// mbcs_pkg: shared types and constants for the Bezier curve sampler
// Widths, controller command bundle and segment status bundle.
// ---------------------------------------------------------------------------
package mbcs_pkg;

   localparam int unsigned SamplesDefault = 20;
   localparam int unsigned CoordW = 24;   // Q16.8 coordinate
   localparam int unsigned WeightW = 16;  // Q4.12 weight
   localparam int unsigned WeightReset = 4096;
   localparam int unsigned KW = 6;        // sample index, covers SAMPLES up to 63
   localparam int unsigned DenW = 29;     // denominator, below 2^28 for any legal setting
   localparam int unsigned AccW = 56;     // weighted sum of three coordinates
   localparam int unsigned QuotW = 24;    // quotient bits

   typedef struct packed {
      logic          load;      // item accepted: build segment, advance history
      logic          wgt1;      // square and cross products of the index
      logic          wgt2;      // blend weights and denominator
      logic          mac_en;    // weighted sum step
      logic [1:0]    mac_sel;   // which control point
      logic          div_init;  // load the dividers
      logic          div_step;  // one quotient bit
      logic [KW-1:0] k;         // sample index
   } cmd_type;

   typedef struct packed {
      logic seg_valid;  // this item closes a segment
      logic seg_last;   // the segment is the final one of its curve
   } status_type;

endpackage

/* src/midpoint_bezier_curve_sampler_core.sv */
// ---------------------------------------------------------------------------
// midpoint_bezier_curve_sampler_core: rational quadratic Bezier sampler
// Takes control points, emits SAMPLES (or SAMPLES+1) samples per segment.
//
//   channel | handshake          | payload
//   req     | req_valid/stall    | point_x, point_y, final_point
//   rsp     | rsp_valid/stall    | sample_x, sample_y, run_end
//   csr     | csr_valid/ready    | weight
//
// Each sample goes through the blend weights, the weighted sums of the
// three control points, the divider load, the bit-serial dividers and
// the hand-over. An item closing a segment is sampled until its last
// sample is handed over, rsp stalls included; other items are taken
// without a stall. Reset is synchronous; req_stall is high while a
// segment is being sampled.
// ---------------------------------------------------------------------------
module midpoint_bezier_curve_sampler_core #(
   parameter int unsigned SAMPLES = mbcs_pkg::SamplesDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbcs_pkg::WeightW-1:0]       csr_weight,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [mbcs_pkg::CoordW-1:0] req_point_x,
   input  logic signed [mbcs_pkg::CoordW-1:0] req_point_y,
   input  logic                               req_final_point,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mbcs_pkg::CoordW-1:0] rsp_sample_x,
   output logic signed [mbcs_pkg::CoordW-1:0] rsp_sample_y,
   output logic                               rsp_run_end
);

   mbcs_pkg::cmd_type    cmd;
   mbcs_pkg::status_type status;

   assign csr_ready = 1'b1;

   mbcs_ctrl #(.SAMPLES(SAMPLES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_run_end (rsp_run_end),
      .status      (status),
      .cmd         (cmd)
   );

   mbcs_dp #(.SAMPLES(SAMPLES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_weight      (csr_weight),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_final_point (req_final_point),
      .cmd             (cmd),
      .status          (status),
      .rsp_sample_x    (rsp_sample_x),
      .rsp_sample_y    (rsp_sample_y)
   );

endmodule

/* src/mbcs_ctrl.sv */
// ---------------------------------------------------------------------------
// mbcs_ctrl: sequencer for the curve sampler
// Walks each segment sample by sample: weights, sums, divide, hand-off.
// ---------------------------------------------------------------------------
module mbcs_ctrl #(
   parameter int unsigned SAMPLES = mbcs_pkg::SamplesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_run_end,
   input  mbcs_pkg::status_type status,
   output mbcs_pkg::cmd_type    cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StWgt1  = 3'd1;
   localparam logic [2:0] StWgt2  = 3'd2;
   localparam logic [2:0] StMac   = 3'd3;
   localparam logic [2:0] StDinit = 3'd4;
   localparam logic [2:0] StDiv   = 3'd5;
   localparam logic [2:0] StOut   = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [4:0]              step_ff, step_in;
   logic [mbcs_pkg::KW-1:0] k_ff, k_in;
   logic                    last_ff, last_in;
   logic                    accept;
   logic                    final_k;

   assign req_stall   = (state_ff != StIdle);
   assign accept      = req_valid && (state_ff == StIdle);
   assign rsp_valid   = (state_ff == StOut);
   assign final_k     = last_ff ? (k_ff == mbcs_pkg::KW'(SAMPLES))
                                : (k_ff == mbcs_pkg::KW'(SAMPLES - 1));
   assign rsp_run_end = final_k;

   // commands
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.wgt1     = (state_ff == StWgt1);
      cmd.wgt2     = (state_ff == StWgt2);
      cmd.mac_en   = (state_ff == StMac);
      cmd.mac_sel  = step_ff[1:0];
      cmd.div_init = (state_ff == StDinit);
      cmd.div_step = (state_ff == StDiv);
      cmd.k        = k_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      case (state_ff)
         StIdle: begin
            if (accept && status.seg_valid) begin
               state_in = StWgt1;
               k_in     = '0;
               last_in  = status.seg_last;
            end
         end
         StWgt1: state_in = StWgt2;
         StWgt2: begin
            state_in = StMac;
            step_in  = '0;
         end
         StMac: begin
            if (step_ff == 5'd2) begin
               state_in = StDinit;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         StDinit: begin
            state_in = StDiv;
            step_in  = '0;
         end
         StDiv: begin
            if (step_ff == 5'(mbcs_pkg::QuotW - 1)) begin
               state_in = StOut;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         StOut: begin
            if (!rsp_stall) begin
               if (final_k) begin
                  state_in = StIdle;
               end else begin
                  state_in = StWgt1;
                  k_in     = k_ff + mbcs_pkg::KW'(1);
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         step_ff  <= '0;
         k_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         last_ff  <= last_in;
      end
   end

endmodule

/* src/mbcs_dp.sv */
// ---------------------------------------------------------------------------
// mbcs_dp: datapath of the curve sampler
// Point history, segment points, blend weights, weighted sums and two
// bit-serial rounding dividers (x and y lanes).
// ---------------------------------------------------------------------------
module mbcs_dp #(
   parameter int unsigned SAMPLES = mbcs_pkg::SamplesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [mbcs_pkg::WeightW-1:0]         csr_weight,
   input  logic signed [mbcs_pkg::CoordW-1:0]   req_point_x,
   input  logic signed [mbcs_pkg::CoordW-1:0]   req_point_y,
   input  logic                                 req_final_point,
   input  mbcs_pkg::cmd_type                    cmd,
   output mbcs_pkg::status_type                 status,
   output logic signed [mbcs_pkg::CoordW-1:0]   rsp_sample_x,
   output logic signed [mbcs_pkg::CoordW-1:0]   rsp_sample_y
);

   localparam int unsigned CW = mbcs_pkg::CoordW;
   localparam int unsigned DW = mbcs_pkg::DenW;
   localparam int unsigned AW = mbcs_pkg::AccW;
   localparam int unsigned QW = mbcs_pkg::QuotW;
   localparam int unsigned KW = mbcs_pkg::KW;

   typedef logic signed [CW-1:0] coord_type;

   // rounded midpoint, ties away from zero
   function automatic coord_type half_round(input coord_type a, input coord_type b);
      logic signed [CW:0] s;
      logic [CW:0]        mag;
      logic [CW:0]        h;
      s   = {a[CW-1], a} + {b[CW-1], b};
      mag = s[CW] ? (CW+1)'(-s) : s;
      h   = (mag + (CW+1)'(1)) >> 1;
      return s[CW] ? CW'(-h) : CW'(h);
   endfunction

   logic [mbcs_pkg::WeightW-1:0] weight_ff;
   coord_type prev_ff [2];
   coord_type older_ff [2];
   logic [1:0] seen_ff;
   coord_type pt_ff [3][2];   // segment points p0, p1, p2 per lane
   coord_type cur [2];
   coord_type mid_prev_cur [2];
   coord_type mid_old_prev [2];

   logic [2*KW-1:0] rr_ff, kr_ff, kk_ff;
   logic [DW-1:0]   ca_ff, cb_ff, cc_ff, den_ff;
   logic [DW-1:0]   cb_term;
   logic [KW:0]     r;

   logic signed [AW-1:0] acc_ff [2];
   logic [DW:0]          rem_ff [2];
   logic [QW-1:0]        quo_ff [2];
   logic                 neg_ff [2];

   assign cur[0] = req_point_x;
   assign cur[1] = req_point_y;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mid_prev_cur[l] = half_round(prev_ff[l], cur[l]);
         mid_old_prev[l] = half_round(older_ff[l], prev_ff[l]);
      end
   end

   assign status.seg_valid = (seen_ff == 2'd1 && req_final_point) || (seen_ff[1] == 1'b1);
   assign status.seg_last  = req_final_point;

   // weight register
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= mbcs_pkg::WeightW'(mbcs_pkg::WeightReset);
      end else if (csr_valid) begin
         weight_ff <= csr_weight;
      end
   end

   // point history and count
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int l = 0; l < 2; l++) begin
            prev_ff[l]  <= '0;
            older_ff[l] <= '0;
         end
      end else if (cmd.load) begin
         for (int l = 0; l < 2; l++) begin
            older_ff[l] <= prev_ff[l];
            prev_ff[l]  <= cur[l];
         end
         if (req_final_point) begin
            seen_ff <= '0;
         end else if (seen_ff != 2'd3) begin
            seen_ff <= seen_ff + 2'd1;
         end
      end
   end

   // segment points
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int l = 0; l < 2; l++) begin
            if (seen_ff == 2'd1) begin
               pt_ff[0][l] <= prev_ff[l];
               pt_ff[1][l] <= mid_prev_cur[l];
               pt_ff[2][l] <= cur[l];
            end else begin
               pt_ff[0][l] <= (seen_ff == 2'd3) ? mid_old_prev[l] : older_ff[l];
               pt_ff[1][l] <= prev_ff[l];
               pt_ff[2][l] <= req_final_point ? cur[l] : mid_prev_cur[l];
            end
         end
      end
   end

   // blend weights: products of the index, then scaled terms and their sum
   assign r = (KW+1)'(SAMPLES) - {1'b0, cmd.k};

   // cross term 2*k*r*weight at full width
   assign cb_term = DW'({DW'(kr_ff) * DW'(weight_ff), 1'b0});

   always_ff @(posedge clock) begin
      if (cmd.wgt1) begin
         rr_ff <= r[KW-1:0] * r[KW-1:0];
         kr_ff <= cmd.k * r[KW-1:0];
         kk_ff <= cmd.k * cmd.k;
      end
      if (cmd.wgt2) begin
         ca_ff  <= DW'({rr_ff, 12'd0});
         cb_ff  <= cb_term;
         cc_ff  <= DW'({kk_ff, 12'd0});
         den_ff <= DW'({rr_ff, 12'd0}) + cb_term + DW'({kk_ff, 12'd0});
      end
   end

   // weighted sums, one point per cycle
   logic [DW-1:0] coef;
   always_comb begin
      case (cmd.mac_sel)
         2'd0:    coef = ca_ff;
         2'd1:    coef = cb_ff;
         default: coef = cc_ff;
      endcase
   end

   logic signed [AW-1:0] prod [2];
   logic [AW-1:0]        mag [2];
   logic [DW:0]          trial [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         prod[l]  = AW'($signed({1'b0, coef}) * pt_ff[cmd.mac_sel][l]);
         mag[l]   = (acc_ff[l][AW-1] ? AW'(-acc_ff[l]) : AW'(acc_ff[l]))
                    + AW'(den_ff >> 1);
         trial[l] = {rem_ff[l][DW-1:0], quo_ff[l][QW-1]};
      end
   end

   // sums and restoring dividers
   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (cmd.mac_en) begin
            acc_ff[l] <= (cmd.mac_sel == 2'd0) ? prod[l] : acc_ff[l] + prod[l];
         end
         if (cmd.div_init) begin
            neg_ff[l] <= acc_ff[l][AW-1];
            rem_ff[l] <= (DW+1)'(mag[l] >> QW);
            quo_ff[l] <= mag[l][QW-1:0];
         end else if (cmd.div_step) begin
            if (trial[l] >= {1'b0, den_ff}) begin
               rem_ff[l] <= trial[l] - {1'b0, den_ff};
               quo_ff[l] <= {quo_ff[l][QW-2:0], 1'b1};
            end else begin
               rem_ff[l] <= trial[l];
               quo_ff[l] <= {quo_ff[l][QW-2:0], 1'b0};
            end
         end
      end
   end

   assign rsp_sample_x = neg_ff[0] ? CW'(-quo_ff[0]) : CW'(quo_ff[0]);
   assign rsp_sample_y = neg_ff[1] ? CW'(-quo_ff[1]) : CW'(quo_ff[1]);

endmodule

/* tb/midpoint_bezier_curve_sampler_core_test.sv */
// ---------------------------------------------------------------------------
// midpoint_bezier_curve_sampler_core_test: self-checking bench for the sampler
// Feeds curves of control points, predicts every curve sample from the
// rational quadratic spline rules and checks each sample as it leaves.
// ---------------------------------------------------------------------------
module midpoint_bezier_curve_sampler_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CoordW      = mbcs_pkg::CoordW;
   localparam int unsigned WeightW     = mbcs_pkg::WeightW;
   localparam int unsigned WeightReset = mbcs_pkg::WeightReset;

   localparam int NSamp = mbcs_pkg::SamplesDefault;
   localparam longint CycleLimit = 4000000;
   localparam int HoldCycles = 600;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic                     fin;
   } point_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic                     run_end;
   } sample_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [WeightW-1:0]       csr_weight = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [CoordW-1:0] req_point_x = '0;
   logic signed [CoordW-1:0] req_point_y = '0;
   logic                     req_final_point = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [CoordW-1:0] rsp_sample_x;
   logic signed [CoordW-1:0] rsp_sample_y;
   logic                     rsp_run_end;

   midpoint_bezier_curve_sampler_core u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_weight      (csr_weight),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_final_point (req_final_point),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_x    (rsp_sample_x),
      .rsp_sample_y    (rsp_sample_y),
      .rsp_run_end     (rsp_run_end)
   );

   // predictor state
   logic [WeightW-1:0] cur_weight = WeightW'(WeightReset);
   int                 hist_px, hist_py, hist_ox, hist_oy;
   int                 curve_count;

   point_type  pending_points[$];
   sample_type expected_samples[$];
   int         error_count = 0;
   longint     cycle_count = 0;
   bit         sender_busy = 1'b0;
   bit         hold_go = 1'b0;
   bit         hold_on = 1'b0;
   int         hold_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int midpoint_round(int a, int b);
      int s;
      s = a + b;
      if (s >= 0) return (s + 1) >>> 1;
      return -((-s + 1) >>> 1);
   endfunction

   function automatic longint quot_round(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
   endfunction

   // queue the samples of one segment
   task automatic predict_segment(int ax, int ay, int bx, int by, int cx, int cy, bit last);
      int     n;
      longint r, wa, wb, wc, den;
      sample_type s;
      n = NSamp + (last ? 1 : 0);
      for (int k = 0; k < n; k++) begin
         r   = NSamp - k;
         wa  = 4096 * r * r;
         wb  = 2 * longint'(k) * r * longint'(cur_weight);
         wc  = 4096 * longint'(k) * k;
         den = wa + wb + wc;
         s.x = CoordW'(quot_round(wa * ax + wb * bx + wc * cx, den));
         s.y = CoordW'(quot_round(wa * ay + wb * by + wc * cy, den));
         s.run_end = (k == n - 1);
         expected_samples = {expected_samples, s};
      end
   endtask

   // apply one accepted control point to the spline history
   task automatic predict_point(point_type p);
      int x, y, sx, sy, ex, ey;
      x = int'(p.x);
      y = int'(p.y);
      if (curve_count == 1 && p.fin) begin
         predict_segment(hist_px, hist_py, midpoint_round(hist_px, x),
                         midpoint_round(hist_py, y), x, y, 1'b1);
      end else if (curve_count >= 2) begin
         sx = hist_ox; sy = hist_oy; ex = x; ey = y;
         if (curve_count == 3) begin
            sx = midpoint_round(hist_ox, hist_px);
            sy = midpoint_round(hist_oy, hist_py);
         end
         if (!p.fin) begin
            ex = midpoint_round(hist_px, x);
            ey = midpoint_round(hist_py, y);
         end
         predict_segment(sx, sy, hist_px, hist_py, ex, ey, p.fin);
      end
      hist_ox = hist_px; hist_oy = hist_py;
      hist_px = x;       hist_py = y;
      if (p.fin) curve_count = 0;
      else if (curve_count < 3) curve_count++;
   endtask

   // driver: one item at a time from the pending queue, random gaps
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_point({req_point_x, req_point_y, req_final_point});
            send_gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
            if (send_gap == 0 && pending_points.size() > 0) begin
               point_type p;
               p = pending_points.pop_front();
               req_point_x <= p.x; req_point_y <= p.y; req_final_point <= p.fin;
            end else begin
               req_valid <= 1'b0;
               sender_busy <= (pending_points.size() > 0);
            end
         end else if (!req_valid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_points.size() > 0) begin
               point_type p;
               p = pending_points.pop_front();
               req_valid <= 1'b1;
               req_point_x <= p.x; req_point_y <= p.y; req_final_point <= p.fin;
               sender_busy <= 1'b1;
            end else sender_busy <= 1'b0;
         end
      end
   end

   // receiver hold-off: one long stretch, counted here
   always @(posedge clock) begin
      if (hold_go && hold_count < HoldCycles) begin
         hold_count <= hold_count + 1;
         hold_on    <= 1'b1;
      end else begin
         hold_on <= 1'b0;
      end
   end

   // monitor: check each sample, draw receiver stalls
   int recv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sample_type e;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample x=%0d y=%0d end=%0b", $time,
                        rsp_sample_x, rsp_sample_y, rsp_run_end);
               error_count++;
            end else begin
               e = expected_samples.pop_front();
               if (e.x !== rsp_sample_x)
                  $display("%0t: sample_x expected %0d actual %0d", $time, e.x, rsp_sample_x);
               if (e.y !== rsp_sample_y)
                  $display("%0t: sample_y expected %0d actual %0d", $time, e.y, rsp_sample_y);
               if (e.run_end !== rsp_run_end)
                  $display("%0t: run_end expected %0b actual %0b", $time, e.run_end,
                           rsp_run_end);
               if (e.x !== rsp_sample_x || e.y !== rsp_sample_y || e.run_end !== rsp_run_end)
                  error_count++;
            end
            recv_gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [CoordW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return {1'b1, {(CoordW-1){1'b0}}};
         1: return {1'b0, {(CoordW-1){1'b1}}};
         2: return CoordW'($urandom_range(0, 2000)) - CoordW'(1000);
         default: return CoordW'($urandom);
      endcase
   endfunction

   task automatic queue_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                              logic fin);
      point_type p;
      p.x = x; p.y = y; p.fin = fin;
      pending_points = {pending_points, p};
   endtask

   // hand all queued items over and wait for every sample
   task automatic drain();
      wait (pending_points.size() == 0);
      @(posedge clock);
      while (sender_busy || req_valid || expected_samples.size() > 0) @(posedge clock);
      repeat (40 * NSamp) @(posedge clock);
   endtask

   task automatic write_weight(logic [WeightW-1:0] w);
      csr_valid  <= 1'b1;
      csr_weight <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_weight = w;
   endtask

   localparam logic signed [CoordW-1:0] CMin = {1'b1, {(CoordW-1){1'b0}}};
   localparam logic signed [CoordW-1:0] CMax = {1'b0, {(CoordW-1){1'b1}}};

   initial begin
      int len;
      hist_px = 0; hist_py = 0; hist_ox = 0; hist_oy = 0; curve_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lone final point, two-point curve, extremes, long curve
      queue_point(CMax, CMin, 1'b1);
      queue_point(CMin, CMax, 1'b0);
      queue_point(CMax, CMin, 1'b1);
      queue_point(CMin, CMin, 1'b0);
      queue_point(CMax, CMax, 1'b0);
      queue_point(CMin, CMax, 1'b1);
      queue_point(CoordW'(0), CoordW'(0), 1'b0);
      queue_point(CoordW'(-1), CoordW'(1), 1'b0);
      queue_point(CoordW'(3), CoordW'(-3), 1'b0);
      queue_point(CMax, CMin, 1'b0);
      queue_point(CoordW'(-5), CoordW'(7), 1'b0);
      queue_point(CoordW'(1), CoordW'(-1), 1'b1);
      drain();

      // zero and full-scale weight
      write_weight('0);
      queue_point(CMin, CMax, 1'b0);
      queue_point(CMax, CMax, 1'b0);
      queue_point(CMax, CMin, 1'b1);
      drain();
      write_weight('1);
      queue_point(CMin, CMax, 1'b0);
      queue_point(CMax, CMin, 1'b0);
      queue_point(CMin, CMax, 1'b0);
      queue_point(CoordW'(100), CoordW'(-100), 1'b1);
      // hold off the receiver while points keep coming
      hold_go = 1'b1;
      queue_point(CMax, CoordW'(0), 1'b0);
      queue_point(CoordW'(0), CMax, 1'b0);
      queue_point(CMin, CoordW'(0), 1'b0);
      queue_point(CoordW'(0), CoordW'(0), 1'b1);
      drain();

      // random curves under several weights
      for (int phase = 0; phase < 5; phase++) begin
         write_weight(phase == 4 ? WeightW'(WeightReset) : WeightW'($urandom));
         for (int c = 0; c < 10; c++) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
            for (int i = 0; i < len; i++)
               queue_point(rand_coord(), rand_coord(),
                           (i == len - 1) ? ($urandom_range(0, 7) != 0) : 1'b0);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
src/mbcs_pkg.sv
src/mbcs_ctrl.sv
src/mbcs_dp.sv
src/midpoint_bezier_curve_sampler_core.sv
tb/midpoint_bezier_curve_sampler_core_test.sv
